[hw/rtl/skwp_pkg.sv]
// Shared types and constants for the skin weight packer.
package skwp_pkg;

    localparam int BONE_W     = 8;
    localparam int WEIGHT_W   = 16;
    localparam int VERTEX_W   = 12;
    localparam int SLOTS      = 4;
    localparam int COUNT_W    = 3;
    localparam int SLOT_IDX_W = 2;
    localparam int SUM_W      = 18;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [VERTEX_W-1:0] vertex_index;
        logic [BONE_W-1:0]   bone_number;
        logic [WEIGHT_W-1:0] influence_weight;
    } request_t;

    typedef struct packed {
        logic [BONE_W-1:0]   bone_id_0;
        logic [BONE_W-1:0]   bone_id_1;
        logic [BONE_W-1:0]   bone_id_2;
        logic [BONE_W-1:0]   bone_id_3;
        logic [WEIGHT_W-1:0] norm_weight_0;
        logic [WEIGHT_W-1:0] norm_weight_1;
        logic [WEIGHT_W-1:0] norm_weight_2;
        logic [WEIGHT_W-1:0] norm_weight_3;
        logic                sum_nonzero;
    } result_t;

    typedef enum logic [1:0] {
        CMD_ADD       = 2'b00,
        CMD_READ      = 2'b01,
        CMD_READ_ZERO = 2'b10
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [VERTEX_W-1:0] vertex;
        logic [BONE_W-1:0]   bone;
        logic [WEIGHT_W-1:0] weight;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                count;
        logic [SLOTS-1:0][BONE_W-1:0]      bones;
        logic [SLOTS-1:0][WEIGHT_W-1:0]    weights;
    } entry_t;

endpackage

[hw/rtl/skwp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module skwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/skwp_fifo.sv]
// Small synchronous queue of a packed type.
module skwp_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hw/rtl/skwp_front.sv]
// Front end: accepts requests, range-checks them and queues commands.
module skwp_front #(
    parameter int unsigned VERTEX_DEPTH = 4096,
    parameter int unsigned BONE_LIMIT   = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  skwp_pkg::request_t request,
    input  logic               clearing,
    input  logic               cmd_pop,
    output skwp_pkg::cmd_t     cmd,
    output logic               cmd_empty
);

    import skwp_pkg::*;

    cmd_t cls;
    logic keep;
    logic in_range;
    logic bone_ok;
    logic q_full;
    logic q_push;

    assign in_range = (32'(request.vertex_index) < VERTEX_DEPTH);
    assign bone_ok  = (32'(request.bone_number) < BONE_LIMIT);

    always_comb
    begin
        cls.vertex = request.vertex_index;
        cls.bone   = request.bone_number;
        cls.weight = request.influence_weight;
        case (request.operation)
            OP_READ:
            begin
                cls.kind = in_range ? CMD_READ : CMD_READ_ZERO;
                keep     = 1'b1;
            end
            default:
            begin
                // Adds outside the table or with a bone beyond the limit vanish here.
                cls.kind = CMD_ADD;
                keep     = in_range && bone_ok;
            end
        endcase
    end

    assign full   = clearing || q_full;
    assign q_push = push && !full && keep;

    skwp_fifo #(
        .T     (cmd_t),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (cls),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

endmodule

[hw/rtl/skwp_div.sv]
// One lane of restoring division: floor(w * 32768 / sum), one quotient bit a cycle while step is high.
module skwp_div (
    input  logic                                clk,
    input  logic                                load,
    input  logic                                step,
    input  logic                                first,
    input  logic [skwp_pkg::WEIGHT_W-1:0]       dividend,
    input  logic [skwp_pkg::SUM_W-1:0]          divisor,
    output logic [skwp_pkg::WEIGHT_W-1:0]       quotient
);

    import skwp_pkg::*;

    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [WEIGHT_W-1:0] quo_reg, quo_next;
    logic [SUM_W:0]      trial;
    logic                fits;

    // The first step tests the weight itself, the later ones shift in zeros.
    assign trial = first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = SUM_W'(dividend);
            quo_next = '0;
        end
        else if (step)
        begin
            rem_next = fits ? SUM_W'(trial - {1'b0, divisor}) : SUM_W'(trial);
            quo_next = {quo_reg[WEIGHT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

[hw/rtl/skwp_back.sv]
// Back end: owns the influence table, applies adds and normalizes reads.
module skwp_back #(
    parameter int unsigned VERTEX_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  skwp_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output logic              res_push,
    output skwp_pkg::result_t res_data,
    input  logic              res_full,
    output logic              clearing
);

    import skwp_pkg::*;

    localparam int ADDR_W = $clog2(VERTEX_DEPTH);
    localparam int STEP_W = $clog2(WEIGHT_W);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOOK  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [ADDR_W-1:0]            clr_addr_reg, clr_addr_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    cmd_t                         cur_reg, cur_next;
    logic [SLOTS-1:0][BONE_W-1:0] bones_reg, bones_next;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic                         nz_reg, nz_next;

    logic                         we, re;
    logic [ADDR_W-1:0]            waddr, raddr;
    entry_t                       wdata, rd, upd;
    logic [SUM_W-1:0]             sum_w;
    logic                         div_load, div_step;
    logic [SLOTS-1:0][WEIGHT_W-1:0] quo;

    skwp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (VERTEX_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd)
    );

    always_comb
    begin
        sum_w = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sum_w = sum_w + SUM_W'(rd.weights[i]);
        end
    end

    always_comb
    begin
        upd = rd;
        upd.bones[rd.count[SLOT_IDX_W-1:0]]   = cur_reg.bone;
        upd.weights[rd.count[SLOT_IDX_W-1:0]] = cur_reg.weight;
        upd.count = rd.count + 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        step_next     = step_reg;
        cur_next      = cur_reg;
        bones_next    = bones_reg;
        sum_next      = sum_reg;
        nz_next       = nz_reg;
        cmd_pop       = 1'b0;
        re            = 1'b0;
        raddr         = ADDR_W'(cmd.vertex);
        we            = 1'b0;
        waddr         = clr_addr_reg;
        wdata         = '0;
        div_load      = 1'b0;
        div_step      = 1'b0;
        res_push      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                if (clr_addr_reg == ADDR_W'(VERTEX_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    if (cmd.kind == CMD_READ_ZERO)
                    begin
                        bones_next = '0;
                        nz_next    = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        re         = 1'b1;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                case (cur_reg.kind)
                    CMD_ADD:
                    begin
                        // A vertex that already holds four influences is left as is.
                        if (rd.count < COUNT_W'(SLOTS))
                        begin
                            we    = 1'b1;
                            waddr = ADDR_W'(cur_reg.vertex);
                            wdata = upd;
                        end
                        state_next = ST_IDLE;
                    end
                    CMD_READ:
                    begin
                        bones_next = rd.bones;
                        sum_next   = sum_w;
                        nz_next    = (sum_w != '0);
                        div_load   = 1'b1;
                        step_next  = '0;
                        state_next = (sum_w != '0) ? ST_DIV : ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                div_step = 1'b1;
                if (step_reg == STEP_W'(WEIGHT_W - 1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_lane
        skwp_div u_div (
            .clk      (clk),
            .load     (div_load),
            .step     (div_step),
            .first    (step_reg == '0),
            .dividend (rd.weights[g]),
            .divisor  (sum_reg),
            .quotient (quo[g])
        );
    end

    always_comb
    begin
        res_data.bone_id_0     = bones_reg[0];
        res_data.bone_id_1     = bones_reg[1];
        res_data.bone_id_2     = bones_reg[2];
        res_data.bone_id_3     = bones_reg[3];
        res_data.norm_weight_0 = nz_reg ? quo[0] : '0;
        res_data.norm_weight_1 = nz_reg ? quo[1] : '0;
        res_data.norm_weight_2 = nz_reg ? quo[2] : '0;
        res_data.norm_weight_3 = nz_reg ? quo[3] : '0;
        res_data.sum_nonzero   = nz_reg;
    end

    assign clearing = (state_reg == ST_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        bones_reg <= bones_next;
        sum_reg   <= sum_next;
        nz_reg    <= nz_next;
    end

endmodule

[hw/rtl/skin_weight_packer.sv]
// Top level of the skin weight packer: front end, back end and result queue.
//
// Requests enter as a queue write: a beat is taken when push is high and full is low.
// An add stores one bone influence in the next free slot of a vertex (at most four);
// adds to a vertex outside the table, with a bone at or above BONE_LIMIT, or to a full
// vertex change nothing and give no result. A read gives one result beat: four bone
// numbers and four weights divided by their sum (Q1.15, truncated), or raw zero weights
// with sum_nonzero low when the sum is zero. A read beyond the table gives all zeros.
// Results leave as a queue read: the oldest is on result while empty is low, and pop
// takes it. A two-entry command queue and a two-entry result queue part the sides.
// The back end handles one command at a time. An add looks up the vertex and writes
// it back; a read goes through table lookup, fetch and sum, the steps of the four
// parallel divider lanes (one quotient bit per cycle), and the hand-off of the beat to
// the result queue. A read whose sum is zero skips the divider, and a read beyond the
// table skips the lookup as well.
// After reset the table is swept clear, one vertex per cycle, with full held high.
// A stalled receiver fills the result queue; the back end then waits, the command queue
// fills, and full rises.
module skin_weight_packer #(
    parameter int unsigned VERTEX_DEPTH = 4096,
    parameter int unsigned BONE_LIMIT   = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  skwp_pkg::request_t request,
    output logic               empty,
    input  logic               pop,
    output skwp_pkg::result_t  result
);

    import skwp_pkg::*;

    cmd_t    cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    clearing;
    logic    res_push;
    logic    res_full;
    result_t res_data;

    skwp_front #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .BONE_LIMIT   (BONE_LIMIT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .clearing  (clearing),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    skwp_back #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_full  (res_full),
        .clearing  (clearing)
    );

    skwp_fifo #(
        .T     (result_t),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // No result can exist before the table sweep has finished.
    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> empty)
        else $error("result pending during table clear");

    a_cmd_pop_nonempty: assert property (
        @(posedge clk) disable iff (!rst_n) cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    a_res_push_room: assert property (
        @(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result written into a full queue");

    // A result that was not normalized carries only zero weights.
    a_zero_sum_weights: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !result.sum_nonzero) |->
            (result.norm_weight_0 == '0) && (result.norm_weight_1 == '0) &&
            (result.norm_weight_2 == '0) && (result.norm_weight_3 == '0))
        else $error("nonzero weight in an unnormalized result");

endmodule

[verif/skin_weight_packer_tb.sv]
// Self-checking testbench for the skin weight packer: directed table, then random traffic.
module skin_weight_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skwp_pkg::*;

    localparam int unsigned VERTEX_DEPTH = 4096;
    localparam int unsigned BONE_LIMIT   = 256;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          IDLE_PCT     = 8;
    localparam int          POOL_SIZE    = 8;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  golden;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     pop = 1'b0;
    request_t request_beat = '0;
    logic     full;
    logic     empty;
    result_t  result_beat;

    // Shadow of the vertex table.
    logic [COUNT_W-1:0]             shadow_count   [VERTEX_DEPTH];
    logic [SLOTS-1:0][BONE_W-1:0]   shadow_bones   [VERTEX_DEPTH];
    logic [SLOTS-1:0][WEIGHT_W-1:0] shadow_weights [VERTEX_DEPTH];

    stim_row_t directed_rows[$];
    result_t   pending_reads[$];
    int        mismatches = 0;
    int        reads_checked = 0;
    int        adds_stored = 0;
    int        adds_dropped = 0;
    int        zero_sum_reads = 0;
    int        stall_cycles = 0;
    bit        steady = 1'b0;

    skin_weight_packer #(
        .VERTEX_DEPTH(VERTEX_DEPTH),
        .BONE_LIMIT  (BONE_LIMIT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .request(request_beat),
        .empty  (empty),
        .pop    (pop),
        .result (result_beat)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic append_row(input stim_row_t s);
        directed_rows.insert(directed_rows.size(), s);
    endtask

    task automatic expect_beat(input result_t b);
        pending_reads.insert(pending_reads.size(), b);
    endtask

    // Updates the shadow table and returns the normalized read beat, if any.
    task automatic apply_request(input request_t r, output bit has_beat, output result_t beat);
        logic [SUM_W-1:0]     total;
        logic [COUNT_W-1:0]   n;
        logic [WEIGHT_W-1:0]  w;
        logic [WEIGHT_W+15:0] scaled;
        logic [SLOTS-1:0][WEIGHT_W-1:0] norm;
        beat = '0;
        has_beat = 1'b0;
        if (r.operation == OP_ADD)
        begin
            if (r.vertex_index >= VERTEX_DEPTH || r.bone_number >= BONE_LIMIT
                || shadow_count[r.vertex_index] >= SLOTS)
            begin
                adds_dropped++;
                return;
            end
            n = shadow_count[r.vertex_index];
            shadow_bones[r.vertex_index][n[SLOT_IDX_W-1:0]] = r.bone_number;
            shadow_weights[r.vertex_index][n[SLOT_IDX_W-1:0]] = r.influence_weight;
            shadow_count[r.vertex_index] = n + 1'b1;
            adds_stored++;
            return;
        end
        has_beat = 1'b1;
        if (r.vertex_index >= VERTEX_DEPTH)
            return;
        total = '0;
        for (int i = 0; i < SLOTS; i++)
            total += shadow_weights[r.vertex_index][i];
        for (int i = 0; i < SLOTS; i++)
        begin
            w = shadow_weights[r.vertex_index][i];
            scaled = {w, 15'd0};
            norm[i] = (total == 0) ? w : WEIGHT_W'(scaled / total);
        end
        beat.bone_id_0     = shadow_bones[r.vertex_index][0];
        beat.bone_id_1     = shadow_bones[r.vertex_index][1];
        beat.bone_id_2     = shadow_bones[r.vertex_index][2];
        beat.bone_id_3     = shadow_bones[r.vertex_index][3];
        beat.norm_weight_0 = norm[0];
        beat.norm_weight_1 = norm[1];
        beat.norm_weight_2 = norm[2];
        beat.norm_weight_3 = norm[3];
        beat.sum_nonzero   = (total != 0);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        string   diff;
        if (pending_reads.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result beat %h", $realtime, got);
            return;
        end
        want = pending_reads.pop_front();
        reads_checked++;
        if (!want.sum_nonzero)
            zero_sum_reads++;
        diff = "";
        if (got.bone_id_0 !== want.bone_id_0) diff = {diff, " bone_id_0"};
        if (got.bone_id_1 !== want.bone_id_1) diff = {diff, " bone_id_1"};
        if (got.bone_id_2 !== want.bone_id_2) diff = {diff, " bone_id_2"};
        if (got.bone_id_3 !== want.bone_id_3) diff = {diff, " bone_id_3"};
        if (got.norm_weight_0 !== want.norm_weight_0) diff = {diff, " norm_weight_0"};
        if (got.norm_weight_1 !== want.norm_weight_1) diff = {diff, " norm_weight_1"};
        if (got.norm_weight_2 !== want.norm_weight_2) diff = {diff, " norm_weight_2"};
        if (got.norm_weight_3 !== want.norm_weight_3) diff = {diff, " norm_weight_3"};
        if (got.sum_nonzero !== want.sum_nonzero) diff = {diff, " sum_nonzero"};
        if (diff != "")
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result mismatch in%s: expected %h, got %h",
                         $realtime, diff, want, got);
        end
    endtask

    // Holds one request beat until the block takes it.
    task automatic send_request(input request_t r);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        request_beat <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic issue(input request_t r, input bit typed, input result_t golden);
        bit      has_beat;
        result_t beat;
        send_request(r);
        apply_request(r, has_beat, beat);
        if (has_beat)
            expect_beat(typed ? golden : beat);
    endtask

    function automatic stim_row_t mk_row(logic op, int vertex, int bone, int weight);
        stim_row_t s;
        s.req.operation        = op;
        s.req.vertex_index     = VERTEX_W'(vertex);
        s.req.bone_number      = BONE_W'(bone);
        s.req.influence_weight = WEIGHT_W'(weight);
        s.typed  = 1'b0;
        s.golden = '0;
        return s;
    endfunction

    function automatic stim_row_t mk_typed(int vertex, result_t golden);
        stim_row_t s;
        s = mk_row(OP_READ, vertex, 0, 0);
        s.typed  = 1'b1;
        s.golden = golden;
        return s;
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'd32768;
            2:       return WEIGHT_W'($urandom_range(65535, 32769));
            3:       return WEIGHT_W'($urandom_range(64));
            default: return WEIGHT_W'($urandom_range(32768));
        endcase
    endfunction

    always @(negedge clk)
        pop <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
        if (rst_n && pop && !empty)
            check_result(result_beat);

    // Ends the run when neither side has moved a beat for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAIL skin_weight_packer");
            $finish;
        end
    end

    initial
    begin
        result_t                   golden;
        request_t                  r;
        logic [VERTEX_W-1:0]       pool[POOL_SIZE];
        int                        pick;
        int                        step;

        for (int v = 0; v < VERTEX_DEPTH; v++)
        begin
            shadow_count[v]   = '0;
            shadow_bones[v]   = '0;
            shadow_weights[v] = '0;
        end

        // Untouched vertices read back as all zero.
        append_row(mk_typed(0, '0));
        append_row(mk_typed(4095, '0));
        // One influence alone normalizes to exactly one.
        append_row(mk_row(OP_ADD, 4095, 255, 65535));
        golden = '0;
        golden.bone_id_0     = 8'd255;
        golden.norm_weight_0 = 16'd32768;
        golden.sum_nonzero   = 1'b1;
        append_row(mk_typed(4095, golden));
        // A used slot with zero weight still gives a zero sum.
        append_row(mk_row(OP_ADD, 1, 0, 0));
        append_row(mk_typed(1, '0));
        // Four influences, then a fifth that the full vertex drops.
        append_row(mk_row(OP_ADD, 2, 1, 32768));
        append_row(mk_row(OP_ADD, 2, 2, 16384));
        append_row(mk_row(OP_ADD, 2, 3, 8192));
        append_row(mk_row(OP_ADD, 2, 4, 8192));
        append_row(mk_row(OP_ADD, 2, 200, 1000));
        append_row(mk_row(OP_READ, 2, 0, 0));
        // Alternating bit patterns with an uneven sum.
        append_row(mk_row(OP_ADD, 3, 170, 16'hAAAA));
        append_row(mk_row(OP_ADD, 3, 85, 16'h5555));
        append_row(mk_row(OP_ADD, 3, 255, 16'hFFFF));
        append_row(mk_row(OP_ADD, 3, 0, 1));
        append_row(mk_row(OP_READ, 3, 0, 0));
        // Weights above one are kept as given and still normalize.
        append_row(mk_row(OP_ADD, 5, 7, 65535));
        append_row(mk_row(OP_ADD, 5, 8, 65535));
        append_row(mk_row(OP_READ, 5, 0, 0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].golden);

        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = VERTEX_W'($urandom_range(VERTEX_DEPTH - 1));

        // Adds and reads mostly hit a small rotating pool so that vertices fill up.
        step = 0;
        while (step < RANDOM_ITEMS)
        begin
            steady = (step >= 150 && step < 300);
            if (step == 450)
            begin
                @(negedge clk);
                push <= 1'b0;
                while (pending_reads.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(9) == 0)
                pool[$urandom_range(POOL_SIZE - 1)] = VERTEX_W'($urandom_range(VERTEX_DEPTH - 1));
            pick = $urandom_range(POOL_SIZE - 1);
            r.operation        = ($urandom_range(99) < 40) ? OP_READ : OP_ADD;
            r.vertex_index     = ($urandom_range(99) < 85) ? pool[pick]
                                 : VERTEX_W'($urandom_range(VERTEX_DEPTH - 1));
            r.bone_number      = BONE_W'($urandom_range(255));
            r.influence_weight = random_weight();
            issue(r, 1'b0, '0);
            step++;
        end
        steady = 1'b0;

        @(negedge clk);
        push <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pending_reads.size();

        $display("covered %0d stored adds, %0d dropped adds, %0d checked reads",
                 adds_stored, adds_dropped, reads_checked);
        $display("%0d reads had a zero weight sum; %0d mismatches",
                 zero_sum_reads, mismatches);
        if (mismatches == 0)
            $display("PASS skin_weight_packer");
        else
            $display("FAIL skin_weight_packer");
        $finish;
    end
endmodule
